FILE: rtl/colpt_pkg.sv
// Shared types, constants and codes for the collision pair test block.
package colpt_pkg;

  localparam int SLOT_W       = 6;
  localparam int OBJECT_SLOTS = 2 ** SLOT_W;
  localparam int FRAC_BITS    = 16;
  localparam int VAL_W        = 32;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COLLIDE = 1'b1;

  localparam logic [1:0] SHP_SPHERE = 2'd0;
  localparam logic [1:0] SHP_PLANE  = 2'd1;
  localparam logic [1:0] SHP_BOX    = 2'd2;
  localparam logic [1:0] SHP_NONE   = 2'd3;

  localparam logic [1:0] LAST_COMP = 2'd2;

  localparam int MA_W      = 54;
  localparam int MD_W      = 16;
  localparam int MUL_STEPS = 3;
  localparam int MB_W      = MD_W * MUL_STEPS;
  localparam int MP_W      = MA_W + MB_W;
  localparam int MCNT_W    = 2;

  localparam int ACC_W  = 68;
  localparam int RAD_W  = ACC_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = 38;
  localparam int NUM_W  = QUO_W + ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int WRK_W  = REM_W + 2;
  localparam int SRC_W  = NUM_W;
  localparam int RCNT_W = 6;

  localparam int D_W    = VAL_W + 1;
  localparam int DIST_W = ROOT_W + 2;
  localparam int S_W    = 53;
  localparam int SAT_W  = MP_W + 1;

  typedef struct packed {
    logic [1:0]              shape;
    logic signed [VAL_W-1:0] p_x;
    logic signed [VAL_W-1:0] p_y;
    logic signed [VAL_W-1:0] p_z;
    logic signed [VAL_W-1:0] q_x;
    logic signed [VAL_W-1:0] q_y;
    logic signed [VAL_W-1:0] q_z;
    logic signed [VAL_W-1:0] extent;
  } obj_t;

  typedef enum logic [1:0] {
    PAIR_NONE,
    PAIR_SS,
    PAIR_BB,
    PAIR_PS
  } pair_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_LATCH_REQ,
    OP_RD_A,
    OP_RD_B,
    OP_LATCH,
    OP_PREP,
    OP_MUL_SQ,
    OP_ACC_SQ,
    OP_SQRT_START,
    OP_DIST,
    OP_MUL_DD,
    OP_DIV_START,
    OP_PUSH_DIV,
    OP_MUL_NC,
    OP_ACC_NC,
    OP_S_CALC,
    OP_MUL_NS,
    OP_PUSH_NS,
    OP_BOX,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic  mul_busy;
    logic  rdu_busy;
    logic  len_zero;
    logic  out_free;
    pair_t pair;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_LATCH,
    S_PREP,
    S_SQ_START,
    S_SQ_WAIT,
    S_SQRT_START,
    S_SQRT_WAIT,
    S_DIST,
    S_LEN_CHK,
    S_DD_START,
    S_DD_WAIT,
    S_DIV_START,
    S_DIV_WAIT,
    S_PUSH_DIV,
    S_NC_START,
    S_NC_WAIT,
    S_S_CALC,
    S_NS_START,
    S_NS_WAIT,
    S_BOX,
    S_EMIT
  } ctl_state_t;

endpackage

FILE: rtl/colpt_mul.sv
// Unsigned multiplier that takes one 16-bit digit of the second operand per cycle.
module colpt_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [colpt_pkg::MA_W-1:0] a,
  input  logic [colpt_pkg::MB_W-1:0] b,
  output logic                     busy,
  output logic [colpt_pkg::MP_W-1:0] prod
);
  import colpt_pkg::*;

  logic [MA_W-1:0]      a_r;
  logic [MB_W-1:0]      bsh;
  logic [MCNT_W-1:0]    cnt;
  logic [MA_W+MD_W-1:0] pp;

  assign pp = (MA_W + MD_W)'(a_r) * (MA_W + MD_W)'(bsh[MB_W-1 -: MD_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= MCNT_W'(MUL_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == MCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      bsh  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= (prod << MD_W) + MP_W'(pp);
      bsh  <= bsh << MD_W;
    end
  end

endmodule

FILE: rtl/colpt_rdu.sv
// Shift-subtract unit: integer square root or long division, one bit per cycle.
module colpt_rdu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start_sqrt,
  input  logic                        start_div,
  input  logic [colpt_pkg::RAD_W-1:0]  rad,
  input  logic [colpt_pkg::NUM_W-1:0]  num,
  input  logic [colpt_pkg::ROOT_W-1:0] den,
  output logic                        busy,
  output logic [colpt_pkg::QUO_W-1:0]  res
);
  import colpt_pkg::*;

  logic              sq_mode;
  logic [REM_W-1:0]  rem;
  logic [SRC_W-1:0]  src;
  logic [ROOT_W-1:0] den_r;
  logic [RCNT_W-1:0] cnt;
  logic [WRK_W-1:0]  work;
  logic [WRK_W-1:0]  trial;
  logic              ge;
  logic [WRK_W-1:0]  diff;

  always_comb begin
    if (sq_mode) begin
      work  = {rem, src[SRC_W-1 -: 2]};
      trial = {1'b0, res[ROOT_W-1:0], 2'b01};
    end else begin
      work  = {1'b0, rem, src[SRC_W-1]};
      trial = WRK_W'(den_r);
    end
    ge   = work >= trial;
    diff = ge ? work - trial : work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start_sqrt) begin
      busy <= 1'b1;
      cnt  <= RCNT_W'(ROOT_W);
    end else if (start_div) begin
      busy <= 1'b1;
      cnt  <= RCNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == RCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sqrt) begin
      sq_mode <= 1'b1;
      rem     <= '0;
      res     <= '0;
      src     <= {rad, {(SRC_W - RAD_W){1'b0}}};
    end else if (start_div) begin
      sq_mode <= 1'b0;
      rem     <= REM_W'(num[NUM_W-1:QUO_W]);
      res     <= '0;
      src     <= {num[QUO_W-1:0], {(SRC_W - QUO_W){1'b0}}};
      den_r   <= den;
    end else if (busy) begin
      rem <= diff[REM_W-1:0];
      res <= {res[QUO_W-2:0], ge};
      src <= sq_mode ? (src << 2) : (src << 1);
    end
  end

endmodule

FILE: rtl/colpt_dp.sv
// Datapath: object store, operand registers, arithmetic units and result register.
module colpt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  colpt_pkg::dp_cmd_t                  cmd,
  output colpt_pkg::dp_stat_t                 stat,
  input  logic [colpt_pkg::SLOT_W-1:0]        slot,
  input  logic [colpt_pkg::SLOT_W-1:0]        other_slot,
  input  logic [1:0]                          shape,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_x,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_y,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_z,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_x,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_y,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_z,
  input  logic signed [colpt_pkg::VAL_W-1:0]  extent,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                hit,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_x,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_y,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_z,
  output logic                                pair_known
);
  import colpt_pkg::*;

  function automatic logic [S_W-1:0] mag(input logic signed [S_W-1:0] v);
    return v[S_W-1] ? S_W'(-v) : S_W'(v);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'($signed({1'b0, {(VAL_W-1){1'b1}}}));
    lo = -hi - SAT_W'(1);
    if (v > hi) return {1'b0, {(VAL_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(VAL_W-1){1'b0}}};
    return v[VAL_W-1:0];
  endfunction

  obj_t                    mem [OBJECT_SLOTS];
  logic [OBJECT_SLOTS-1:0] vld;
  obj_t                    rdata;
  obj_t                    ra;
  obj_t                    rb;
  obj_t                    wobj;
  logic                    rvld;
  logic                    va;
  logic                    vb;
  logic [SLOT_W-1:0]       self_r;
  logic [SLOT_W-1:0]       other_r;
  logic [SLOT_W-1:0]       raddr;

  logic signed [VAL_W-1:0] ap [3];
  logic signed [VAL_W-1:0] aq [3];
  logic signed [VAL_W-1:0] bp [3];
  logic signed [VAL_W-1:0] bq [3];

  logic signed [D_W-1:0]    d [3];
  logic signed [D_W-1:0]    rsum;
  logic signed [ACC_W-1:0]  acc;
  logic [ROOT_W-1:0]        len_r;
  logic signed [DIST_W-1:0] sep;
  logic signed [DIST_W-1:0] sep_next;
  logic signed [S_W-1:0]    s;
  logic signed [S_W-1:0]    s_next;
  logic                     pl_a;
  logic                     hit_r;
  logic                     known_r;
  logic signed [VAL_W-1:0]  push_r [3];

  logic [1:0]               sa;
  logic [1:0]               sb;
  pair_t                    pair;
  obj_t                     pl;
  obj_t                     sp;
  logic signed [VAL_W-1:0]  n_sel;
  logic signed [VAL_W-1:0]  c_sel;
  logic signed [D_W-1:0]    d_sel;

  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic                     mul_start;
  logic                     mul_busy;
  logic [MP_W-1:0]          prod;
  logic                     rdu_busy;
  logic [QUO_W-1:0]         rdu_res;

  logic signed [QUO_W:0]    q_sgn;
  logic signed [SAT_W-1:0]  ns_full;
  logic signed [SAT_W-1:0]  ns_shift;
  logic signed [D_W-1:0]    gap [3];
  logic signed [D_W-1:0]    g1 [3];
  logic signed [D_W-1:0]    g2 [3];

  assign wobj = '{shape: shape, p_x: p_x, p_y: p_y, p_z: p_z,
                  q_x: q_x, q_y: q_y, q_z: q_z, extent: extent};
  assign raddr = (cmd.op == OP_RD_B) ? other_r : self_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[slot] <= wobj;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      rvld <= vld[raddr];
      if (cmd.op == OP_WRITE) begin
        vld[slot] <= 1'b1;
      end
    end
  end

  assign ap[0] = ra.p_x;
  assign ap[1] = ra.p_y;
  assign ap[2] = ra.p_z;
  assign aq[0] = ra.q_x;
  assign aq[1] = ra.q_y;
  assign aq[2] = ra.q_z;
  assign bp[0] = rb.p_x;
  assign bp[1] = rb.p_y;
  assign bp[2] = rb.p_z;
  assign bq[0] = rb.q_x;
  assign bq[1] = rb.q_y;
  assign bq[2] = rb.q_z;

  always_comb begin
    sa = va ? ra.shape : SHP_NONE;
    sb = vb ? rb.shape : SHP_NONE;
    if (sa == SHP_SPHERE && sb == SHP_SPHERE) begin
      pair = PAIR_SS;
    end else if (sa == SHP_BOX && sb == SHP_BOX) begin
      pair = PAIR_BB;
    end else if ((sa == SHP_PLANE && sb == SHP_SPHERE) ||
                 (sa == SHP_SPHERE && sb == SHP_PLANE)) begin
      pair = PAIR_PS;
    end else begin
      pair = PAIR_NONE;
    end
  end

  always_comb begin
    pl    = pl_a ? ra : rb;
    sp    = pl_a ? rb : ra;
    d_sel = d[cmd.comp];
    unique case (cmd.comp)
      2'd0: begin
        n_sel = pl.p_x;
        c_sel = sp.p_x;
      end
      2'd1: begin
        n_sel = pl.p_y;
        c_sel = sp.p_y;
      end
      default: begin
        n_sel = pl.p_z;
        c_sel = sp.p_z;
      end
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b1;
    case (cmd.op)
      OP_MUL_SQ: begin
        mul_a = MA_W'(mag(S_W'(d_sel)));
        mul_b = MB_W'(mag(S_W'(d_sel)));
      end
      OP_MUL_DD: begin
        mul_a = MA_W'(mag(S_W'(sep)));
        mul_b = MB_W'(mag(S_W'(d_sel)));
      end
      OP_MUL_NC: begin
        mul_a = MA_W'(mag(S_W'(n_sel)));
        mul_b = MB_W'(mag(S_W'(c_sel)));
      end
      OP_MUL_NS: begin
        mul_a = MA_W'(mag(s));
        mul_b = MB_W'(mag(S_W'(n_sel)));
      end
      default: mul_start = 1'b0;
    endcase
  end

  colpt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  colpt_rdu u_rdu (
    .clk        (clk),
    .rst        (rst),
    .start_sqrt (cmd.op == OP_SQRT_START),
    .start_div  (cmd.op == OP_DIV_START),
    .rad        (RAD_W'(acc)),
    .num        (prod[NUM_W-1:0]),
    .den        (len_r),
    .busy       (rdu_busy),
    .res        (rdu_res)
  );

  always_comb begin
    sep_next = $signed({2'b00, rdu_res[ROOT_W-1:0]}) - DIST_W'(rsum);
    s_next   = S_W'(pl.extent) + S_W'(acc >>> FRAC_BITS) - S_W'(sp.extent);
    q_sgn    = (d_sel[D_W-1] ^ sep[DIST_W-1]) ? -$signed({1'b0, rdu_res})
                                              : $signed({1'b0, rdu_res});
    ns_full  = (n_sel[VAL_W-1] ^ s[S_W-1]) ? -$signed({1'b0, prod})
                                           : $signed({1'b0, prod});
    ns_shift = ns_full >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      g1[i]  = D_W'(bp[i]) - D_W'(aq[i]);
      g2[i]  = D_W'(ap[i]) - D_W'(bq[i]);
      gap[i] = (g1[i] > g2[i]) ? g1[i] : g2[i];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH_REQ: begin
        self_r  <= slot;
        other_r <= other_slot;
      end
      OP_RD_B: begin
        ra <= rdata;
        va <= rvld;
      end
      OP_LATCH: begin
        rb <= rdata;
        vb <= rvld;
      end
      OP_PREP: begin
        for (int i = 0; i < 3; i++) begin
          d[i]      <= D_W'(bp[i]) - D_W'(ap[i]);
          push_r[i] <= '0;
        end
        rsum    <= D_W'(ra.extent) + D_W'(rb.extent);
        acc     <= '0;
        hit_r   <= 1'b0;
        known_r <= (pair != PAIR_NONE);
        pl_a    <= (sa == SHP_PLANE);
      end
      OP_ACC_SQ: acc <= acc + $signed(prod[ACC_W-1:0]);
      OP_ACC_NC: begin
        if (n_sel[VAL_W-1] ^ c_sel[VAL_W-1]) begin
          acc <= acc - $signed(prod[ACC_W-1:0]);
        end else begin
          acc <= acc + $signed(prod[ACC_W-1:0]);
        end
      end
      OP_DIST: begin
        sep   <= sep_next;
        hit_r <= sep_next[DIST_W-1];
        len_r <= rdu_res[ROOT_W-1:0];
      end
      OP_PUSH_DIV: push_r[cmd.comp] <= sat(SAT_W'(q_sgn));
      OP_S_CALC: begin
        s     <= s_next;
        hit_r <= s_next[S_W-1];
      end
      OP_PUSH_NS: push_r[cmd.comp] <= sat(ns_shift);
      OP_BOX: begin
        for (int i = 0; i < 3; i++) begin
          push_r[i] <= sat(SAT_W'(gap[i]));
        end
        hit_r <= gap[0][D_W-1] & gap[1][D_W-1] & gap[2][D_W-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      hit        <= hit_r;
      push_x     <= push_r[0];
      push_y     <= push_r[1];
      push_z     <= push_r[2];
      pair_known <= known_r;
    end
  end

  assign stat = '{mul_busy: mul_busy, rdu_busy: rdu_busy, len_zero: (len_r == '0),
                  out_free: (!out_valid || out_ready), pair: pair};

endmodule

FILE: rtl/colpt_ctrl.sv
// Controller: sequences object loads and pair tests through the datapath.
module colpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                req_type,
  output logic                in_ready,
  input  colpt_pkg::dp_stat_t stat,
  output colpt_pkg::dp_cmd_t  cmd
);
  import colpt_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic [1:0] comp;
  logic [1:0] comp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp  <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
    end
  end

  always_comb begin
    state_next = state;
    comp_next  = comp;
    cmd        = '{op: OP_NONE, comp: comp};
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == REQ_LOAD) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op     = OP_LATCH_REQ;
            state_next = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        cmd.op     = OP_RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.op     = OP_RD_B;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.op     = OP_LATCH;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        comp_next = '0;
        unique case (stat.pair)
          PAIR_SS: state_next = S_SQ_START;
          PAIR_BB: state_next = S_BOX;
          PAIR_PS: state_next = S_NC_START;
          default: state_next = S_EMIT;
        endcase
      end
      S_SQ_START: begin
        cmd.op     = OP_MUL_SQ;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_ACC_SQ;
          if (comp == LAST_COMP) begin
            comp_next  = '0;
            state_next = S_SQRT_START;
          end else begin
            comp_next  = comp + 1'b1;
            state_next = S_SQ_START;
          end
        end
      end
      S_SQRT_START: begin
        cmd.op     = OP_SQRT_START;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!stat.rdu_busy) begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.op     = OP_DIST;
        state_next = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        state_next = stat.len_zero ? S_EMIT : S_DD_START;
      end
      S_DD_START: begin
        cmd.op     = OP_MUL_DD;
        state_next = S_DD_WAIT;
      end
      S_DD_WAIT: begin
        if (!stat.mul_busy) begin
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.rdu_busy) begin
          state_next = S_PUSH_DIV;
        end
      end
      S_PUSH_DIV: begin
        cmd.op = OP_PUSH_DIV;
        if (comp == LAST_COMP) begin
          comp_next  = '0;
          state_next = S_EMIT;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = S_DD_START;
        end
      end
      S_NC_START: begin
        cmd.op     = OP_MUL_NC;
        state_next = S_NC_WAIT;
      end
      S_NC_WAIT: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_ACC_NC;
          if (comp == LAST_COMP) begin
            comp_next  = '0;
            state_next = S_S_CALC;
          end else begin
            comp_next  = comp + 1'b1;
            state_next = S_NC_START;
          end
        end
      end
      S_S_CALC: begin
        cmd.op     = OP_S_CALC;
        state_next = S_NS_START;
      end
      S_NS_START: begin
        cmd.op     = OP_MUL_NS;
        state_next = S_NS_WAIT;
      end
      S_NS_WAIT: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_PUSH_NS;
          if (comp == LAST_COMP) begin
            comp_next  = '0;
            state_next = S_EMIT;
          end else begin
            comp_next  = comp + 1'b1;
            state_next = S_NS_START;
          end
        end
      end
      S_BOX: begin
        cmd.op     = OP_BOX;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_div_by_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV_START |-> !stat.len_zero)
    else $error("division started with zero length");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(stat.mul_busy && stat.rdu_busy))
    else $error("multiplier and root/divide unit busy together");

  a_sqrt_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SQRT_START |=> stat.rdu_busy)
    else $error("square root did not start");
`endif

endmodule

FILE: rtl/collision_pair_test_core.sv
// Top level of the narrow-phase collision pair test block.
// A collide item reads both slots and then runs on one shared multiplier and one
// shift-subtract unit; a sphere pair uses the 34-step square root and three 38-step
// divisions. Other or empty pairs are emitted with pair_known low. One collide is
// worked at a time, and a waiting result holds off the next collide at its end.
module collision_pair_test_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [colpt_pkg::SLOT_W-1:0]        slot,
  input  logic [colpt_pkg::SLOT_W-1:0]        other_slot,
  input  logic [1:0]                          shape,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_x,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_y,
  input  logic signed [colpt_pkg::VAL_W-1:0]  p_z,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_x,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_y,
  input  logic signed [colpt_pkg::VAL_W-1:0]  q_z,
  input  logic signed [colpt_pkg::VAL_W-1:0]  extent,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_x,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_y,
  output logic signed [colpt_pkg::VAL_W-1:0]  push_z,
  output logic                                pair_known
);
  import colpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  colpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  colpt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .slot       (slot),
    .other_slot (other_slot),
    .shape      (shape),
    .p_x        (p_x),
    .p_y        (p_y),
    .p_z        (p_z),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_z        (q_z),
    .extent     (extent),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .hit        (hit),
    .push_x     (push_x),
    .push_y     (push_y),
    .push_z     (push_z),
    .pair_known (pair_known)
  );

endmodule
